// ===== rtl/core/dpc_pkg.sv =====
// Shared types, constants and elaboration-time table builders for the
// dew point condensation check. No dependencies.
`default_nettype none

package dpc_pkg;

  // Field widths
  localparam int TEMP_W  = 15;
  localparam int HUM_W   = 14;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 24;

  // Log table geometry
  localparam int LOG_DEPTH = 256;
  localparam int LOG_IDX_W = $clog2(LOG_DEPTH);
  localparam int LOG_W     = 24;
  localparam int FRAC_W    = HUM_W - 1;
  localparam int LTERM_W   = 32;

  // Divider chain: quotient, divisor and remainder share one width
  localparam int DIV_W = 30;
  localparam int NUM_W = 2 * DIV_W;

  // Fixed point constants, Q24 where noted
  localparam int Q_SHIFT = 24;
  localparam int LN2_Q24 = 11629080;
  localparam int A_Q24   = 295614546;
  localparam int A_CENTI = 1762;
  localparam int B_CENTI = 24312;
  localparam int DEW_MIN = -10500;
  localparam int DEW_MAX = 8500;
  localparam int HUM_REF = 10000;

  typedef logic [0:LOG_DEPTH][LOG_W-1:0] log_rom_t;

  // Per-request sideband carried along the divider chains
  typedef struct packed {
    logic                      dew_ok;
    logic                      out_ok;
    logic signed [TEMP_W-1:0]  t_out;
    logic                      neg;
    logic                      force_max;
    logic signed [LTERM_W-1:0] aux;
  } side_t;

  // One divider cell's state
  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] low;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] dvs;
    side_t            side;
  } div_stage_t;

  // Shift-subtract quotient, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/D) in Q24 through the atanh series
  function automatic logic [63:0] log_entry(int i);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] pw;
    logic [63:0] sum;
    z   = udiv64(64'(i) << 30, 64'(2 * LOG_DEPTH + i));
    z2  = (z * z) >> 30;
    pw  = z;
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      if (pw != 0) begin
        sum = sum + udiv64(pw, 64'(2 * k + 1));
        pw  = (pw * z2) >> 30;
      end
    end
    return (2 * sum + 64'd32) >> 6;
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    for (int i = 0; i <= LOG_DEPTH; i++) begin
      rom[i] = LOG_W'(log_entry(i));
    end
    return rom;
  endfunction

  // Table log of a constant humidity code
  function automatic int lnq_const(logic [HUM_W-1:0] h);
    int          e;
    logic [HUM_W-1:0] m;
    logic [63:0] p;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] lo;
    logic [63:0] hi;
    e = 0;
    for (int b = 0; b < HUM_W; b++) begin
      if (h[b]) e = b;
    end
    m    = h << (HUM_W - 1 - e);
    p    = 64'(m[FRAC_W-1:0]) * 64'(LOG_DEPTH);
    idx  = p >> FRAC_W;
    frac = p & ((64'd1 << FRAC_W) - 64'd1);
    lo   = log_entry(int'(idx));
    hi   = log_entry(int'(idx) + 1);
    return int'(64'(e) * 64'(LN2_Q24) + lo + (((hi - lo) * frac) >> FRAC_W));
  endfunction

  localparam int LN_REF_Q24 = lnq_const(HUM_W'(HUM_REF));

endpackage

`default_nettype wire

// ===== rtl/core/dew_point_condensation_check_top.sv =====
// Pipeline: 3 front stages, two 30-cell divider chains, 3 middle stages
// and one output register; the divider cell rows are fully pipelined.
// Throughput: one request per cycle while the output is not stalled.
// The output register lets the pipeline keep filling while a result waits.
// Reset: rst_ni asynchronous, active low, clears all valid bits; no init pass.
// Depends on dpc_pkg, dpc_log_unit, dpc_div_chain.
`default_nettype none

module dew_point_condensation_check_top import dpc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // temp_inside[14:0], humidity[28:15], temp_outside[43:29],
  // temp_inside_valid[44], humidity_valid[45], temp_outside_valid[46]
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // dew_point[14:0], dew_valid[15], condensation_risk[16], risk_valid[17]
  output logic [M_DATA_W-1:0]      m_axis_tdata
);

  localparam int MAG_W   = 25;
  localparam int GABS_W  = 31;
  localparam int PROD2_W = GABS_W + 15;

  logic signed [TEMP_W-1:0] t_in;
  logic [HUM_W-1:0]         hum;
  logic [TEMP_W-1:0]        t_mag;
  logic signed [16:0]       bsum;
  side_t                    side_d;

  logic                     en;
  logic                     move;

  logic                     b_valid_q;
  logic [MAG_W-1:0]         b_mag_q;
  logic [DIV_W-1:0]         b_dvs_q;
  side_t                    b_side_q;
  logic                     c_valid_q;
  logic [NUM_W-1:0]         c_num_q;
  logic [DIV_W-1:0]         c_dvs_q;
  side_t                    c_side_q;
  logic                     d_valid_q;
  logic [NUM_W-1:0]         d_num_q;
  logic [DIV_W-1:0]         d_dvs_q;
  side_t                    d_side_q;
  logic signed [LTERM_W-1:0] lterm;

  div_stage_t               c1_in;
  div_stage_t               c1_out;
  logic signed [LTERM_W-1:0] q1s;
  logic                     f_valid_q;
  logic signed [LTERM_W-1:0] f_g_q;
  side_t                    f_side_q;
  logic [GABS_W-1:0]        gabs;
  logic signed [32:0]       den;
  side_t                    g_side_d;
  logic                     g_valid_q;
  logic [PROD2_W-1:0]       g_prod_q;
  logic [DIV_W-1:0]         g_den_q;
  side_t                    g_side_q;
  logic                     h_valid_q;
  logic [NUM_W-1:0]         h_num_q;
  logic [DIV_W-1:0]         h_dvs_q;
  side_t                    h_side_q;

  div_stage_t               c2_in;
  div_stage_t               c2_out;
  logic signed [31:0]       dp;
  logic signed [31:0]       dsat;
  logic                     risk;
  logic [TEMP_W-1:0]        dew_pt;

  logic                     o_valid_q;
  logic [M_DATA_W-1:0]      o_data_q;

  // pipeline advances unless a held result would be overwritten
  assign move          = !o_valid_q || m_axis_tready;
  assign en            = move || !c2_out.valid;
  assign s_axis_tready = en;

  // input unpack and front stage terms
  always_comb begin
    t_in  = signed'(s_axis_tdata[14:0]);
    hum   = s_axis_tdata[28:15];
    t_mag = t_in[TEMP_W-1] ? TEMP_W'(-t_in) : TEMP_W'(t_in);
    bsum  = 17'(t_in) + 17'(B_CENTI);
    side_d.dew_ok    = s_axis_tdata[44] && s_axis_tdata[45] && (hum != '0);
    side_d.out_ok    = s_axis_tdata[46];
    side_d.t_out     = signed'(s_axis_tdata[43:29]);
    side_d.neg       = t_in[TEMP_W-1];
    side_d.force_max = 1'b0;
    side_d.aux       = '0;
  end

  dpc_log_unit u_log (
    .clk_i   (clk_i),
    .en_i    (en),
    .hum_i   (hum),
    .lterm_o (lterm)
  );

  // valid bits of the front and middle stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= s_axis_tvalid;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      f_valid_q <= c1_out.valid;
      g_valid_q <= f_valid_q;
      h_valid_q <= g_valid_q;
    end
  end

  // fraction term numerator and divisor, then delay to meet the log term
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_mag_q  <= MAG_W'(t_mag) * MAG_W'(A_CENTI);
      b_dvs_q  <= DIV_W'(bsum[15:0]) * DIV_W'(100);
      b_side_q <= side_d;
      c_num_q  <= (NUM_W'(b_mag_q) << Q_SHIFT) + NUM_W'(b_dvs_q >> 1);
      c_dvs_q  <= b_dvs_q;
      c_side_q <= b_side_q;
      d_num_q  <= c_num_q;
      d_dvs_q  <= c_dvs_q;
      d_side_q <= c_side_q;
    end
  end

  always_comb begin
    c1_in.valid    = d_valid_q;
    c1_in.rem      = d_num_q[NUM_W-1:DIV_W];
    c1_in.low      = d_num_q[DIV_W-1:0];
    c1_in.quo      = '0;
    c1_in.dvs      = d_dvs_q;
    c1_in.side     = d_side_q;
    c1_in.side.aux = lterm;
  end

  dpc_div_chain u_div_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stage_i (c1_in),
    .stage_o (c1_out)
  );

  // gamma = log term + signed fraction term
  assign q1s = c1_out.side.neg ? -signed'(LTERM_W'(c1_out.quo))
                               : signed'(LTERM_W'(c1_out.quo));

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_g_q    <= c1_out.side.aux + q1s;
      f_side_q <= c1_out.side;
    end
  end

  // dew point numerator magnitude and denominator a - gamma
  always_comb begin
    gabs               = f_g_q[LTERM_W-1] ? GABS_W'(-f_g_q) : GABS_W'(f_g_q);
    den                = 33'(A_Q24) - 33'(f_g_q);
    g_side_d           = f_side_q;
    g_side_d.neg       = f_g_q[LTERM_W-1];
    g_side_d.force_max = den[32] || (den == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_prod_q <= PROD2_W'(gabs) * PROD2_W'(B_CENTI);
      g_den_q  <= den[DIV_W-1:0];
      g_side_q <= g_side_d;
      h_num_q  <= NUM_W'(g_prod_q) + NUM_W'(g_den_q >> 1);
      h_dvs_q  <= g_den_q;
      h_side_q <= g_side_q;
    end
  end

  always_comb begin
    c2_in.valid = h_valid_q;
    c2_in.rem   = h_num_q[NUM_W-1:DIV_W];
    c2_in.low   = h_num_q[DIV_W-1:0];
    c2_in.quo   = '0;
    c2_in.dvs   = h_dvs_q;
    c2_in.side  = h_side_q;
  end

  dpc_div_chain u_div_dew (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stage_i (c2_in),
    .stage_o (c2_out)
  );

  // sign, saturation and risk compare on the unsaturated value
  always_comb begin
    if (c2_out.side.force_max) begin
      dp = 32'(DEW_MAX);
    end else if (c2_out.side.neg) begin
      dp = -signed'(32'(c2_out.quo));
    end else begin
      dp = signed'(32'(c2_out.quo));
    end
    if (dp > 32'(DEW_MAX)) begin
      dsat = 32'(DEW_MAX);
    end else if (dp < 32'(DEW_MIN)) begin
      dsat = 32'(DEW_MIN);
    end else begin
      dsat = dp;
    end
    risk   = c2_out.side.dew_ok && c2_out.side.out_ok
             && (32'(c2_out.side.t_out) <= dp);
    dew_pt = c2_out.side.dew_ok ? dsat[TEMP_W-1:0] : '0;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (move) begin
      o_valid_q <= c2_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && c2_out.valid) begin
      o_data_q <= {6'b0,
                   c2_out.side.dew_ok && c2_out.side.out_ok,
                   risk,
                   c2_out.side.dew_ok,
                   dew_pt};
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (o_valid_q && c2_out.valid))
    else $error("pipeline stalled with room to advance");

  a_invalid_dew_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[15]) |-> (m_axis_tdata[14:0] == '0
      && !m_axis_tdata[17]))
    else $error("invalid dew point carries data");

  a_risk_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[16]) |-> m_axis_tdata[17])
    else $error("risk flagged without valid risk");

  a_dew_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (signed'(m_axis_tdata[14:0]) <= 15'(DEW_MAX)
      && signed'(m_axis_tdata[14:0]) >= signed'(15'(DEW_MIN))))
    else $error("dew point outside saturation range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dpc_log_unit.sv =====
// Three-stage table log of the humidity code, minus the log of 100 percent.
// Depends on dpc_pkg.
`default_nettype none

module dpc_log_unit import dpc_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [HUM_W-1:0]          hum_i,
  output logic signed [LTERM_W-1:0]      lterm_o
);

  localparam log_rom_t LOG_ROM = build_log_rom();
  localparam int P_W    = FRAC_W + LOG_IDX_W;
  localparam int E_W    = $clog2(HUM_W);
  localparam int PROD_W = LOG_W + FRAC_W;

  logic [E_W-1:0]       e_d;
  logic [HUM_W-1:0]     m_d;
  logic [P_W-1:0]       p_d;
  logic [E_W-1:0]       b_e_q;
  logic [LOG_IDX_W-1:0] b_idx_q;
  logic [FRAC_W-1:0]    b_frac_q;
  logic [E_W-1:0]       c_e_q;
  logic [FRAC_W-1:0]    c_frac_q;
  logic [LOG_W-1:0]     c_lo_q;
  logic [LOG_W-1:0]     c_hi_q;
  logic [LOG_W-1:0]     diff;
  logic [PROD_W-1:0]    d_prod_q;
  logic [LTERM_W-1:0]   d_base_q;

  // normalize: top set bit and mantissa split into index and fraction
  always_comb begin
    e_d = '0;
    for (int b = 0; b < HUM_W; b++) begin
      if (hum_i[b]) e_d = E_W'(b);
    end
    m_d = hum_i << (E_W'(HUM_W - 1) - e_d);
    p_d = P_W'(32'(m_d[FRAC_W-1:0]) * LOG_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_e_q    <= e_d;
      b_idx_q  <= p_d[P_W-1:FRAC_W];
      b_frac_q <= p_d[FRAC_W-1:0];
    end
  end

  // table lookup at both ends of the segment
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_e_q    <= b_e_q;
      c_frac_q <= b_frac_q;
      c_lo_q   <= LOG_ROM[{1'b0, b_idx_q}];
      c_hi_q   <= LOG_ROM[(LOG_IDX_W + 1)'(b_idx_q) + 1'b1];
    end
  end

  // interpolation product and exponent term
  assign diff = c_hi_q - c_lo_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_prod_q <= PROD_W'(diff) * PROD_W'(c_frac_q);
      d_base_q <= LTERM_W'(c_e_q) * LTERM_W'(LN2_Q24) + LTERM_W'(c_lo_q);
    end
  end

  assign lterm_o = signed'(d_base_q + LTERM_W'(d_prod_q >> FRAC_W)
                           - LTERM_W'(LN_REF_Q24));

endmodule

`default_nettype wire

// ===== rtl/core/dpc_div_cell.sv =====
// One restoring-division cell: takes one numerator bit, yields one quotient bit.
// Depends on dpc_pkg.
`default_nettype none

module dpc_div_cell import dpc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire div_stage_t stage_i,
  output div_stage_t      stage_o
);

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;
  div_stage_t     nxt;
  div_stage_t     data_q;
  logic           valid_q;

  // shift in next numerator bit, subtract divisor when it fits
  always_comb begin
    trial    = {stage_i.rem, stage_i.low[DIV_W-1]};
    diff     = trial - {1'b0, stage_i.dvs};
    ge       = trial >= {1'b0, stage_i.dvs};
    nxt      = stage_i;
    nxt.rem  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    nxt.low  = stage_i.low << 1;
    nxt.quo  = {stage_i.quo[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= nxt;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/dpc_div_chain.sv =====
// Row of DIV_W division cells, one quotient bit per cell per cycle while en_i is high.
// Depends on dpc_pkg and dpc_div_cell.
`default_nettype none

module dpc_div_chain import dpc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire div_stage_t stage_i,
  output div_stage_t      stage_o
);

  div_stage_t link [DIV_W+1];

  assign link[0] = stage_i;

  for (genvar g = 0; g < DIV_W; g++) begin : g_cell
    dpc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .stage_i (link[g]),
      .stage_o (link[g+1])
    );
  end

  assign stage_o = link[DIV_W];

endmodule

`default_nettype wire
